FILE: rtl/dprc_pkg.sv
// shared types and constants for the depth pixel colorize and range block
`timescale 1ns / 1ps

package dprc_pkg;

    // field widths
    localparam int COLOR_W    = 8;
    localparam int DIST_W     = 24;
    localparam int NUM_W      = 10;
    localparam int OFS_W      = 20;
    localparam int SLOPE_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUMERATOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE     = 2'd2;

    // configuration reset values
    localparam logic [NUM_W-1:0]   NUM_RESET   = 10'd100;
    localparam logic [OFS_W-1:0]   OFS_RESET   = 20'd218235;
    localparam logic [SLOPE_W-1:0] SLOPE_RESET = 16'd201;

    // cubic gamma curve: level = 9 * code^3 >> GAMMA_SHIFT
    localparam int GAMMA_SHIFT = 23;

    // rainbow segments picked by level bits 8 and up
    localparam logic [23:0] SEG_WHITE_RED    = 24'd0;
    localparam logic [23:0] SEG_RED_YELLOW   = 24'd1;
    localparam logic [23:0] SEG_YELLOW_GREEN = 24'd2;
    localparam logic [23:0] SEG_GREEN_CYAN   = 24'd3;
    localparam logic [23:0] SEG_CYAN_BLUE    = 24'd4;
    localparam logic [23:0] SEG_BLUE_BLACK   = 24'd5;

    localparam logic [COLOR_W-1:0] COLOR_FULL = 8'hFF;
    localparam logic [COLOR_W-1:0] COLOR_NONE = 8'h00;

    // distance limits, signed q15.8
    localparam logic [DIST_W-1:0] DIST_MAX = 24'h7FFFFF;
    localparam logic [DIST_W-1:0] DIST_MIN = 24'h800000;

    // side information that travels with the divider
    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic               valid_res;
        logic               neg;
        logic               sat_pre;
    } dprc_side_t;

    // one finished result beat
    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [DIST_W-1:0]  distance;
        logic               valid_res;
        logic               saturated;
    } dprc_result_t;

endpackage

FILE: rtl/depth_pixel_colorize_and_range.sv
// top level of the depth pixel colorizer and range converter
`timescale 1ns / 1ps

// channel | handshake              | payload                                          | beat
// --------+------------------------+--------------------------------------------------+---------------
// input   | in_valid / in_stall    | depth_code                                       | valid && !stall
// output  | out_valid / out_stall  | red, green, blue, distance, valid_res, saturated | valid && !stall
// config  | cfg_valid / cfg_ready  | cfg_index, cfg_data                              | valid && ready
//
// one pixel per cycle sustained while out_stall is low; the pipe is 3 front stages, 24 stages of the
// restoring divider (one quotient bit each) and the output register
// reset clears valid bits and the skid flag, and loads the default coefficients
// in_stall comes from a flop: it is high only while the skid stage holds a beat
// a stalled output keeps one more beat in the skid stage, then the whole pipe holds
// coefficients are taken straight into the front stages, so write them only when idle

module depth_pixel_colorize_and_range
    import dprc_pkg::*;
#(
    parameter int DEPTH_BITS = 11
) (
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [DEPTH_BITS-1:0]    depth_code,

    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [COLOR_W-1:0]       red,
    output logic [COLOR_W-1:0]       green,
    output logic [COLOR_W-1:0]       blue,
    output logic signed [DIST_W-1:0] distance,
    output logic                     valid_res,
    output logic                     saturated,

    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data
);

    localparam int MAG_W     = SLOPE_W + DEPTH_BITS;
    localparam int DIV_STEPS = DIST_W;

    // coefficient registers
    logic [NUM_W-1:0]   numerator_reg;
    logic [OFS_W-1:0]   offset_reg;
    logic [SLOPE_W-1:0] slope_reg;

    logic en;

    // divider chain, entry 0 is the front output
    logic [DIV_STEPS:0] chain_valid;
    dprc_side_t         chain_side [DIV_STEPS+1];
    logic [MAG_W-1:0]   chain_rem  [DIV_STEPS+1];
    logic [MAG_W-1:0]   chain_mag  [DIV_STEPS+1];
    logic [DIST_W-1:0]  chain_quo  [DIV_STEPS+1];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            numerator_reg <= NUM_RESET;
            offset_reg    <= OFS_RESET;
            slope_reg     <= SLOPE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_NUMERATOR: numerator_reg <= cfg_data[NUM_W-1:0];
                CFG_OFFSET:    offset_reg    <= cfg_data[OFS_W-1:0];
                CFG_SLOPE:     slope_reg     <= cfg_data[SLOPE_W-1:0];
                default:       ;   // unused index, write dropped
            endcase
        end
    end

    // input beat enters stage 1 whenever the pipe moves
    assign in_stall = !en;

    // square, cube, denominator magnitude, overflow check and colour
    dprc_front #(
        .DEPTH_BITS (DEPTH_BITS)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .en               (en),
        .up_valid         (in_valid),
        .depth_code       (depth_code),
        .range_numerator  (numerator_reg),
        .range_offset_q16 (offset_reg),
        .range_slope_q16  (slope_reg),
        .dn_valid         (chain_valid[0]),
        .dn_side          (chain_side[0]),
        .dn_rem           (chain_rem[0]),
        .dn_mag           (chain_mag[0])
    );

    assign chain_quo[0] = '0;

    // numerator * 2^24 / magnitude, one quotient bit per stage, msb first
    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        dprc_div_stage #(
            .MAG_W (MAG_W)
        ) u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .up_valid (chain_valid[i]),
            .up_side  (chain_side[i]),
            .up_rem   (chain_rem[i]),
            .up_mag   (chain_mag[i]),
            .up_quo   (chain_quo[i]),
            .dn_valid (chain_valid[i+1]),
            .dn_side  (chain_side[i+1]),
            .dn_rem   (chain_rem[i+1]),
            .dn_mag   (chain_mag[i+1]),
            .dn_quo   (chain_quo[i+1])
        );
    end

    // sign, clipping and the output handshake
    dprc_out_skid u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (chain_valid[DIV_STEPS]),
        .up_side   (chain_side[DIV_STEPS]),
        .up_quo    (chain_quo[DIV_STEPS]),
        .en        (en),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .distance  (distance),
        .valid_res (valid_res),
        .saturated (saturated)
    );

endmodule

FILE: rtl/dprc_front.sv
// front stages: products, denominator magnitude and rainbow colour
`timescale 1ns / 1ps

module dprc_front
    import dprc_pkg::*;
#(
    parameter int DEPTH_BITS = 11
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          up_valid,
    input  logic [DEPTH_BITS-1:0]         depth_code,
    input  logic [NUM_W-1:0]              range_numerator,
    input  logic [OFS_W-1:0]              range_offset_q16,
    input  logic [SLOPE_W-1:0]            range_slope_q16,
    output logic                          dn_valid,
    output dprc_side_t                    dn_side,
    output logic [SLOPE_W+DEPTH_BITS-1:0] dn_rem,
    output logic [SLOPE_W+DEPTH_BITS-1:0] dn_mag
);

    localparam int SQ_W   = 2 * DEPTH_BITS;
    localparam int CUBE_W = 3 * DEPTH_BITS;
    localparam int NC_W   = CUBE_W + 4;
    localparam int MAG_W  = SLOPE_W + DEPTH_BITS;

    // stage 1: square and slope product
    logic                  s1_valid_reg;
    logic [DEPTH_BITS-1:0] s1_code_reg;
    logic [SQ_W-1:0]       s1_sq_reg;
    logic [MAG_W-1:0]      s1_sub_reg;
    logic                  s1_ok_reg;

    // stage 2: cube and denominator magnitude
    logic                  s2_valid_reg;
    logic [CUBE_W-1:0]     s2_cube_reg;
    logic [MAG_W-1:0]      s2_mag_reg;
    logic                  s2_neg_reg;
    logic                  s2_zero_reg;
    logic                  s2_ok_reg;

    // stage 3 outputs
    logic                  valid_reg;
    dprc_side_t            side_reg;
    logic [MAG_W-1:0]      rem_reg;
    logic [MAG_W-1:0]      mag_reg;

    logic                  code_ok;
    logic [MAG_W-1:0]      ofs_ext;
    logic [NC_W-1:0]       nine_cube;
    logic [31:0]           level;
    logic [23:0]           seg;
    logic [COLOR_W-1:0]    lb;
    logic                  ovf;
    dprc_side_t            side_next;

    assign code_ok = (depth_code != '0) && (depth_code != '1);
    assign ofs_ext = MAG_W'(range_offset_q16);

    // 9 * cube as shift and add
    assign nine_cube = {1'b0, s2_cube_reg, 3'b000} + NC_W'(s2_cube_reg);
    assign level     = 32'(nine_cube >> GAMMA_SHIFT);
    assign seg       = level[31:8];
    assign lb        = level[7:0];

    // quotient reaches 2^24 exactly when numerator >= magnitude
    assign ovf = (MAG_W'(range_numerator) >= s2_mag_reg);

    always_comb
    begin
        side_next           = '0;
        side_next.valid_res = s2_ok_reg;
        side_next.neg       = s2_neg_reg;
        side_next.sat_pre   = s2_zero_reg || ovf;
        unique case (seg)
            SEG_WHITE_RED:
            begin
                side_next.red   = COLOR_FULL;
                side_next.green = COLOR_FULL - lb;
                side_next.blue  = COLOR_FULL - lb;
            end
            SEG_RED_YELLOW:
            begin
                side_next.red   = COLOR_FULL;
                side_next.green = lb;
                side_next.blue  = COLOR_NONE;
            end
            SEG_YELLOW_GREEN:
            begin
                side_next.red   = COLOR_FULL - lb;
                side_next.green = COLOR_FULL;
                side_next.blue  = COLOR_NONE;
            end
            SEG_GREEN_CYAN:
            begin
                side_next.red   = COLOR_NONE;
                side_next.green = COLOR_FULL;
                side_next.blue  = lb;
            end
            SEG_CYAN_BLUE:
            begin
                side_next.red   = COLOR_NONE;
                side_next.green = COLOR_FULL - lb;
                side_next.blue  = COLOR_FULL;
            end
            SEG_BLUE_BLACK:
            begin
                side_next.red   = COLOR_NONE;
                side_next.green = COLOR_NONE;
                side_next.blue  = COLOR_FULL - lb;
            end
            default:
            begin
                side_next.red   = COLOR_NONE;
                side_next.green = COLOR_NONE;
                side_next.blue  = COLOR_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= up_valid;
            s2_valid_reg <= s1_valid_reg;
            valid_reg    <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_code_reg <= depth_code;
            s1_sq_reg   <= depth_code * depth_code;
            s1_sub_reg  <= range_slope_q16 * depth_code;
            s1_ok_reg   <= code_ok;

            s2_cube_reg <= s1_sq_reg * s1_code_reg;
            if (ofs_ext >= s1_sub_reg)
            begin
                s2_mag_reg <= ofs_ext - s1_sub_reg;
                s2_neg_reg <= 1'b0;
            end
            else
            begin
                s2_mag_reg <= s1_sub_reg - ofs_ext;
                s2_neg_reg <= 1'b1;
            end
            s2_zero_reg <= (ofs_ext == s1_sub_reg);
            s2_ok_reg   <= s1_ok_reg;

            side_reg <= side_next;
            rem_reg  <= MAG_W'(range_numerator);
            mag_reg  <= s2_mag_reg;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_side  = side_reg;
    assign dn_rem   = rem_reg;
    assign dn_mag   = mag_reg;

endmodule

FILE: rtl/dprc_div_stage.sv
// one restoring division step, one quotient bit per stage
`timescale 1ns / 1ps

module dprc_div_stage
    import dprc_pkg::*;
#(
    parameter int MAG_W = 27
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              up_valid,
    input  dprc_side_t        up_side,
    input  logic [MAG_W-1:0]  up_rem,
    input  logic [MAG_W-1:0]  up_mag,
    input  logic [DIST_W-1:0] up_quo,
    output logic              dn_valid,
    output dprc_side_t        dn_side,
    output logic [MAG_W-1:0]  dn_rem,
    output logic [MAG_W-1:0]  dn_mag,
    output logic [DIST_W-1:0] dn_quo
);

    logic              valid_reg;
    dprc_side_t        side_reg;
    logic [MAG_W-1:0]  rem_reg;
    logic [MAG_W-1:0]  mag_reg;
    logic [DIST_W-1:0] quo_reg;

    logic [MAG_W:0]    shifted;
    logic [MAG_W:0]    diff;
    logic              ge;
    logic [MAG_W-1:0]  rem_next;

    // dividend low bits are all zero, so only a zero shifts in
    assign shifted  = {up_rem, 1'b0};
    assign diff     = shifted - {1'b0, up_mag};
    assign ge       = (shifted >= {1'b0, up_mag});
    assign rem_next = ge ? diff[MAG_W-1:0] : shifted[MAG_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= up_side;
            rem_reg  <= rem_next;
            mag_reg  <= up_mag;
            quo_reg  <= {up_quo[DIST_W-2:0], ge};
        end
    end

    assign dn_valid = valid_reg;
    assign dn_side  = side_reg;
    assign dn_rem   = rem_reg;
    assign dn_mag   = mag_reg;
    assign dn_quo   = quo_reg;

endmodule

FILE: rtl/dprc_out_skid.sv
// distance clipping, output register and skid stage
`timescale 1ns / 1ps

module dprc_out_skid
    import dprc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      up_valid,
    input  dprc_side_t                up_side,
    input  logic [DIST_W-1:0]         up_quo,
    output logic                      en,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [COLOR_W-1:0]        red,
    output logic [COLOR_W-1:0]        green,
    output logic [COLOR_W-1:0]        blue,
    output logic signed [DIST_W-1:0]  distance,
    output logic                      valid_res,
    output logic                      saturated
);

    logic         out_valid_reg;
    logic         full_reg;
    dprc_result_t res_reg;
    dprc_result_t skid_reg;
    dprc_result_t fin_res;

    always_comb
    begin
        fin_res           = '0;
        fin_res.red       = up_side.red;
        fin_res.green     = up_side.green;
        fin_res.blue      = up_side.blue;
        fin_res.valid_res = up_side.valid_res;
        priority if (!up_side.valid_res)
        begin
            fin_res.distance  = DIST_MIN;
            fin_res.saturated = 1'b0;
        end
        else if (up_side.sat_pre)
        begin
            fin_res.distance  = up_side.neg ? DIST_MIN : DIST_MAX;
            fin_res.saturated = 1'b1;
        end
        else if (!up_side.neg)
        begin
            fin_res.saturated = (up_quo > DIST_MAX);
            fin_res.distance  = (up_quo > DIST_MAX) ? DIST_MAX : up_quo;
        end
        else
        begin
            fin_res.saturated = (up_quo > DIST_MIN);
            fin_res.distance  = (up_quo > DIST_MIN) ? DIST_MIN : (~up_quo) + 24'd1;
        end
    end

    // pipeline moves whenever the skid stage is empty
    assign en = !full_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            full_reg      <= 1'b0;
        end
        else if (full_reg)
        begin
            if (!out_stall)
            begin
                out_valid_reg <= 1'b1;
                full_reg      <= 1'b0;
            end
        end
        else if (!out_valid_reg || !out_stall)
        begin
            out_valid_reg <= up_valid;
        end
        else if (up_valid)
        begin
            full_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (full_reg)
        begin
            if (!out_stall)
            begin
                res_reg <= skid_reg;
            end
        end
        else if (!out_valid_reg || !out_stall)
        begin
            res_reg <= fin_res;
        end
        else
        begin
            skid_reg <= fin_res;
        end
    end

    assign out_valid = out_valid_reg;
    assign red       = res_reg.red;
    assign green     = res_reg.green;
    assign blue      = res_reg.blue;
    assign distance  = $signed(res_reg.distance);
    assign valid_res = res_reg.valid_res;
    assign saturated = res_reg.saturated;

`ifndef ASSERT_OFF
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg |-> out_valid_reg)
        else $error("skid holds a beat while the output is empty");

    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg && out_stall |=> full_reg && $stable(skid_reg))
        else $error("skid beat lost under stall");

    a_invalid_dist: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !res_reg.valid_res |->
            res_reg.distance == DIST_MIN && !res_reg.saturated)
        else $error("no-reading pixel with wrong distance");

    a_sat_limits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.saturated |->
            res_reg.distance == DIST_MAX || res_reg.distance == DIST_MIN)
        else $error("saturated distance not at a limit");
`endif

endmodule
